FILE: sv/memory_request_spec_parser_assert.svh
// Assertion macros for the memory request parser.
// Included by RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef MEMORY_REQUEST_SPEC_PARSER_ASSERT_SVH
`define MEMORY_REQUEST_SPEC_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MRSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrsp check failed");

// Next-cycle implication, checked out of reset.
`define MRSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrsp check failed");

`endif

FILE: sv/mrsp_pkg.sv
// Shared types, character codes and digit helpers for the memory request parser.
// No dependencies; imported by mrsp_out_buf and memory_request_spec_parser.
package mrsp_pkg;

  localparam logic [7:0]  CHAR_COMMA       = 8'h2C;
  localparam logic [7:0]  CHAR_COLON       = 8'h3A;
  localparam logic [20:0] MAX_LENGTH_RESET = 21'd4096;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [63:0] address;
    logic [20:0] length;
    logic [12:0] data_offset;
  } out_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Shift in one nibble, saturating to all ones once the top nibble is occupied.
  function automatic logic [63:0] push_digit(input logic [63:0] acc, input logic [3:0] d);
    logic [63:0] r;
    if (acc[63:60] != 4'd0) begin
      r = '1;
    end else begin
      r = {acc[59:0], d};
    end
    return r;
  endfunction

endpackage

FILE: sv/memory_request_spec_parser.sv
// Memory request parser: one packet byte per cycle, one request result per packet.
// Output: a result shows on out_valid in the cycle after its last byte is accepted
// when the result buffer is free; a stalled output delays it further.
// Throughput: one byte per cycle; a two-entry result buffer keeps input flowing
// while a result waits, and in_stall rises only when both entries are full.
// Reset (sync, rst_n low): parser state cleared, max_length = 4096, buffer empty.
`include "memory_request_spec_parser_assert.svh"

module memory_request_spec_parser
  import mrsp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_ADDR,
    PH_LEN,
    PH_DONE,
    PH_FAIL
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [63:0]      addr_r, addr_nxt;
  logic             addr_seen_r, addr_seen_nxt;
  logic [63:0]      len_r, len_nxt;
  logic             len_seen_r, len_seen_nxt;
  logic [12:0]      off_r, off_nxt;
  logic [20:0]      max_length_r;

  logic             in_acc;
  logic             buf_full;
  logic [4:0]       hex;
  logic [POS_W-1:0] off_sat;
  logic [POS_W+12:0] off_ext;
  logic             ok;
  out_t             res;
  logic             out_fields_zero;

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !in_stall;
  assign hex      = hex_decode(in_data.packet_byte);

  // byte index after the current one, capped at the packet size
  assign off_sat = (pos_r == MAX_POS) ? MAX_POS : pos_r + 1'b1;
  assign off_ext = {13'd0, off_sat};

  always_comb begin
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    addr_seen_nxt = addr_seen_r;
    len_nxt       = len_r;
    len_seen_nxt  = len_seen_r;
    off_nxt       = off_r;
    pos_nxt       = (pos_r == MAX_POS) ? pos_r : pos_r + 1'b1;
    case (phase_r)
      PH_FIRST: begin
        phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        if (hex[4]) begin
          addr_nxt      = push_digit(addr_r, hex[3:0]);
          addr_seen_nxt = 1'b1;
        end else if (in_data.packet_byte == CHAR_COMMA && addr_seen_r) begin
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_LEN: begin
        if (hex[4]) begin
          len_nxt      = push_digit(len_r, hex[3:0]);
          len_seen_nxt = 1'b1;
        end else if (len_seen_r) begin
          if (in_data.packet_byte == CHAR_COLON) begin
            off_nxt = off_ext[12:0];
          end
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      default: begin
      end
    endcase
  end

  assign ok = (phase_nxt == PH_DONE) || (phase_nxt == PH_LEN && len_seen_nxt);

  always_comb begin
    res = '0;
    if (ok) begin
      res.parse_ok    = 1'b1;
      res.address     = addr_nxt;
      res.length      = (len_nxt > {43'd0, max_length_r}) ? max_length_r : len_nxt[20:0];
      res.data_offset = off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      pos_r        <= '0;
      addr_r       <= '0;
      addr_seen_r  <= 1'b0;
      len_r        <= '0;
      len_seen_r   <= 1'b0;
      off_r        <= '0;
      max_length_r <= MAX_LENGTH_RESET;
    end else begin
      if (cfg_we) begin
        max_length_r <= cfg_wdata;
      end
      if (in_acc) begin
        if (in_data.last_byte) begin
          phase_r     <= PH_FIRST;
          pos_r       <= '0;
          addr_r      <= '0;
          addr_seen_r <= 1'b0;
          len_r       <= '0;
          len_seen_r  <= 1'b0;
          off_r       <= '0;
        end else begin
          phase_r     <= phase_nxt;
          pos_r       <= pos_nxt;
          addr_r      <= addr_nxt;
          addr_seen_r <= addr_seen_nxt;
          len_r       <= len_nxt;
          len_seen_r  <= len_seen_nxt;
          off_r       <= off_nxt;
        end
      end
    end
  end

  mrsp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_acc && in_data.last_byte),
    .push_data  (res),
    .buf_full   (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_fields_zero = out_data.address == 64'd0 && out_data.length == 21'd0 &&
                           out_data.data_offset == 13'd0;

  // a malformed request carries all-zero fields
  `MRSP_ASSERT_NOW(a_fail_zero, out_valid && !out_data.parse_ok, out_fields_zero)
  // the last byte always returns the parser to the start of a packet
  `MRSP_ASSERT_NEXT(a_last_clears, in_acc && in_data.last_byte, phase_r == PH_FIRST && pos_r == '0)
  // input only backs up when a result is already waiting
  `MRSP_ASSERT_NOW(a_stall_has_out, in_stall, out_valid)
  `MRSP_ASSERT_NOW(a_pos_sat, 1'b1, pos_r <= MAX_POS)

endmodule

FILE: sv/mrsp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on mrsp_pkg (out_t).
module mrsp_out_buf
  import mrsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  out_t push_data,
  output logic buf_full,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic main_v_r, main_v_nxt;
  out_t main_d_r, main_d_nxt;
  logic skid_v_r, skid_v_nxt;
  out_t skid_d_r, skid_d_nxt;
  logic pop;

  assign pop = main_v_r && !out_stall;

  // push is never raised while the skid entry is occupied
  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push_valid;
        main_d_nxt = push_data;
      end
    end else if (push_valid) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign buf_full  = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule
